// ----- design/dhps_pkg.sv -----
// Shared types and constants for the double-hash probe start block.
// Holds the hash constants, the sequencer state type and the divider sizing.
// No dependencies.
package dhps_pkg;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;
   localparam logic [31:0] CAP_RESET = 32'd31;

   // Bit-serial remainder unit: one quotient bit per cycle
   localparam int unsigned DIV_STEPS = 32;
   localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FINISH,
      ST_DIV_BASE,
      ST_DIV_STEP,
      ST_DONE
   } dhps_state_type;

endpackage

// ----- design/double_hash_probe_start.sv -----
// Double-hash probe start: FNV-1a and one-at-a-time hashing of a key stream,
// followed by base index and probe stride. Depends on dhps_pkg.
//
// Key bytes come in one item per cycle while the block is idle; an item with
// has_byte set is absorbed in the cycle it is accepted, the last one too. The
// item marked last starts a sequence of one-at-a-time finalization, then two
// passes of one shared bit-serial remainder unit (FNV modulo the capacity,
// then the finalized hash modulo capacity minus one), then a move of the
// result into the output register: req_tready stays low from a last item
// until that move, which waits while a previous result still sits on the
// result side. A remainder by a zero divisor reads as zero. The capacity
// register must only be written while no key is in flight.
module double_hash_probe_start
   import dhps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // Key byte items
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] key_byte
   input  logic         req_tuser,   // has_byte
   input  logic         req_tlast,   // last_byte
   // Result items
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // [31:0] fnv_hash, [63:32] oaat_hash,
                                     // [95:64] home_slot, [127:96] probe_step
   // Capacity register
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data
);

   dhps_state_type state_ff, state_in;

   logic [31:0] cap_ff;
   logic [31:0] fnv_ff,  fnv_in;
   logic [31:0] oaat_ff, oaat_in;
   logic [31:0] rem_ff,  rem_in;
   logic [31:0] dvd_ff,  dvd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0] base_ff, base_in;
   logic [31:0] step_ff, step_in;
   logic        out_valid_ff, out_valid_in;
   logic [127:0] out_data_ff, out_data_in;

   logic        accept;
   logic        out_free;
   logic        cnt_last;
   logic [31:0] cap_m1;
   logic [31:0] divisor;
   logic [32:0] rem_sh;
   logic [32:0] rem_diff;
   logic [31:0] rem_next;
   logic [31:0] fnv_mix;
   logic [31:0] fnv_prod;
   logic [31:0] oaat_a, oaat_b, oaat_upd;
   logic [31:0] fin_a, fin_b, fin_c;

   // Control strobes from the sequencer
   logic        absorb_byte;
   logic        load_fin;
   logic        div_run;
   logic        load_out;

   assign accept   = req_tvalid & req_tready;
   assign out_free = ~out_valid_ff | rsp_tready;
   assign cnt_last = (cnt_ff == CNT_W'(DIV_STEPS - 1));
   assign cap_m1   = cap_ff - 32'd1;

   // Byte mixing for both hashes
   assign fnv_mix  = fnv_ff ^ {24'd0, req_tdata};
   assign fnv_prod = fnv_mix * FNV_PRIME;
   assign oaat_a   = oaat_ff + {24'd0, req_tdata};
   assign oaat_b   = oaat_a + (oaat_a << 10);
   assign oaat_upd = oaat_b ^ (oaat_b >> 6);

   // One-at-a-time finalization
   assign fin_a = oaat_ff + (oaat_ff << 3);
   assign fin_b = fin_a ^ (fin_a >> 11);
   assign fin_c = fin_b + (fin_b << 15);

   // Shared restoring remainder step
   assign divisor  = (state_ff == ST_DIV_STEP) ? cap_m1 : cap_ff;
   assign rem_sh   = {rem_ff, dvd_ff[31]};
   assign rem_diff = rem_sh - {1'b0, divisor};
   assign rem_next = rem_diff[32] ? rem_sh[31:0] : rem_diff[31:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_tlast) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = ST_DIV_BASE;
         end
         ST_DIV_BASE: begin
            if (cnt_last) state_in = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            if (cnt_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready  = 1'b0;
      absorb_byte = 1'b0;
      load_fin    = 1'b0;
      div_run     = 1'b0;
      load_out    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            absorb_byte = req_tvalid & req_tuser;
         end
         ST_FINISH:   load_fin = 1'b1;
         ST_DIV_BASE: div_run  = 1'b1;
         ST_DIV_STEP: div_run  = 1'b1;
         ST_DONE:     load_out = out_free;
         default:     req_tready = 1'b0;
      endcase
   end

   // Datapath next values
   always_comb begin
      fnv_in       = fnv_ff;
      oaat_in      = oaat_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      cnt_in       = cnt_ff;
      base_in      = base_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;
      out_data_in  = out_data_ff;

      // absorb a key byte into both accumulators
      if (absorb_byte) begin
         fnv_in  = fnv_prod;
         oaat_in = oaat_upd;
      end

      // finalize and start the base index remainder
      if (load_fin) begin
         oaat_in = fin_c;
         rem_in  = 32'd0;
         dvd_in  = fnv_ff;
         cnt_in  = '0;
      end

      // advance the shared remainder unit
      if (div_run) begin
         rem_in = rem_next;
         dvd_in = {dvd_ff[30:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_last) begin
            if (state_ff == ST_DIV_BASE) begin
               base_in = (cap_ff == 32'd0) ? 32'd0 : rem_next;
               rem_in  = 32'd0;
               dvd_in  = oaat_ff;
               cnt_in  = '0;
            end else begin
               step_in = ((cap_m1 == 32'd0) ? 32'd0 : rem_next) + 32'd1;
            end
         end
      end

      // hand off the result and clear the accumulators
      if (load_out) begin
         out_valid_in = 1'b1;
         out_data_in  = {step_ff, base_ff, oaat_ff, fnv_ff};
         fnv_in       = FNV_BASIS;
         oaat_in      = 32'd0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         fnv_ff       <= FNV_BASIS;
         oaat_ff      <= 32'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fnv_ff       <= fnv_in;
         oaat_ff      <= oaat_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) cap_ff <= csr_wr_data;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      cnt_ff      <= cnt_in;
      base_ff     <= base_in;
      step_ff     <= step_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
